@@ hdl/nec_irfg_pkg.sv @@
// package for the nec ir frame generator: opcodes, register indexes,
// register reset values and the shared structs; no dependencies
`timescale 1ns / 1ps

package nec_irfg_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } nec_op_e;

  localparam int unsigned UnitsW = 12;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned StepW  = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_LEADER_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEADER_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHORT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_GAP  = 3'd4;

  localparam logic [UnitsW-1:0] LEADER_LOW_RST  = 12'h156;
  localparam logic [UnitsW-1:0] LEADER_HIGH_RST = 12'h0AB;
  localparam logic [UnitsW-1:0] SHORT_RST       = 12'h015;
  localparam logic [UnitsW-1:0] LONG_RST        = 12'h040;
  localparam logic [UnitsW-1:0] REPEAT_GAP_RST  = 12'h5F0;

  localparam logic [StepW-1:0] STEP_LEADER_LOW  = 7'd0;
  localparam logic [StepW-1:0] STEP_LEADER_HIGH = 7'd1;
  localparam logic [StepW-1:0] STEP_STOP        = 7'd66;
  localparam logic [StepW-1:0] STEP_LAST        = 7'd67;

  typedef struct packed {
    logic [UnitsW-1:0] leader_low;
    logic [UnitsW-1:0] leader_high;
    logic [UnitsW-1:0] short_len;
    logic [UnitsW-1:0] long_len;
    logic [UnitsW-1:0] repeat_gap;
  } nec_cfg_t;

  typedef struct packed {
    logic              stop;
    logic              reload;
    logic [UnitsW-1:0] delay;
    logic              pend_level;
    logic [StepW-1:0]  next_step;
  } nec_sched_t;

  typedef struct packed {
    logic ir_level;
    logic active;
    logic edge_res;
  } nec_res_t;

endpackage

@@ hdl/nec_irfg_in_if.sv @@
// input channel of the nec ir frame generator: valid, ready, opcode and key
// depends on nothing
`timescale 1ns / 1ps

interface nec_irfg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink (input valid, input opcode, input key_code, output ready);
endinterface

@@ hdl/nec_irfg_out_if.sv @@
// result channel of the nec ir frame generator: valid, ready and line status
// depends on nothing
`timescale 1ns / 1ps

interface nec_irfg_out_if;
  logic valid;
  logic ready;
  logic ir_level;
  logic active;
  logic edge_res;

  modport source (output valid, output ir_level, output active, output edge_res,
                  input ready);
  modport sink (input valid, input ir_level, input active, input edge_res,
                output ready);
endinterface

@@ hdl/nec_ir_frame_generator_unit.sv @@
// top level of the nec ir frame generator: timing registers, core and queue
// depends on nec_irfg_pkg, both channel interfaces, nec_irfg_core, nec_irfg_obuf
`timescale 1ns / 1ps

// Takes one item (tick, key press, key release) per clock cycle and returns
// one result per item: line level, frame active and line edge. The line state
// is updated in the cycle of the transfer; the result is registered in a
// two-entry output queue and appears on the result channel from there. The
// input is ready whenever that queue has room, so it stalls only when two
// results are left untaken. Timing registers are written through the
// plain write port, index 0 to 4; other indexes are ignored.

module nec_ir_frame_generator_unit
  import nec_irfg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [UnitsW-1:0]  cfg_wdata_i,
  nec_irfg_in_if.sink        in_ch_i,
  nec_irfg_out_if.source     out_ch_o
);

  nec_cfg_t cfg_q;
  nec_res_t res;
  nec_res_t out_res;
  logic     room;
  logic     fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low  <= LEADER_LOW_RST;
      cfg_q.leader_high <= LEADER_HIGH_RST;
      cfg_q.short_len   <= SHORT_RST;
      cfg_q.long_len    <= LONG_RST;
      cfg_q.repeat_gap  <= REPEAT_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LEADER_LOW:  cfg_q.leader_low  <= cfg_wdata_i;
        REG_LEADER_HIGH: cfg_q.leader_high <= cfg_wdata_i;
        REG_SHORT:       cfg_q.short_len   <= cfg_wdata_i;
        REG_LONG:        cfg_q.long_len    <= cfg_wdata_i;
        REG_REPEAT_GAP:  cfg_q.repeat_gap  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ch_i.ready = room;
  assign fire          = in_ch_i.valid && room;

  nec_irfg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .opcode_i   (in_ch_i.opcode),
    .key_code_i (in_ch_i.key_code),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  nec_irfg_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (out_ch_o.valid),
    .ready_i     (out_ch_o.ready),
    .data_o      (out_res)
  );

  assign out_ch_o.ir_level = out_res.ir_level;
  assign out_ch_o.active   = out_res.active;
  assign out_ch_o.edge_res = out_res.edge_res;

endmodule

@@ hdl/nec_irfg_sched.sv @@
// edge scheduler: delay, next level and next step after the edge of one step
// depends on nec_irfg_pkg
`timescale 1ns / 1ps

module nec_irfg_sched
  import nec_irfg_pkg::*;
(
  input  logic [StepW-1:0] step_i,
  input  logic [KeyW-1:0]  frame_code_i,
  input  logic [KeyW-1:0]  held_key_i,
  input  nec_cfg_t         cfg_i,
  output nec_sched_t       sched_o
);

  logic [StepW-1:0] step_off;
  logic [4:0]       bit_idx;
  logic [3:0]       src_idx;
  logic             bit_one;

  assign step_off = step_i - 7'd2;
  assign bit_idx  = step_off[5:1];
  assign src_idx  = {bit_idx[4], bit_idx[2:0]};
  // second and fourth byte are sent inverted
  assign bit_one  = frame_code_i[src_idx] ^ bit_idx[3];

  always_comb begin
    sched_o.stop       = 1'b0;
    sched_o.reload     = 1'b0;
    sched_o.pend_level = ~step_i[0];
    sched_o.next_step  = (step_i == STEP_LAST) ? '0 : step_i + 7'd1;
    if (step_i == STEP_LEADER_LOW) begin
      sched_o.delay = cfg_i.leader_low;
    end else if (step_i == STEP_LEADER_HIGH) begin
      sched_o.delay = cfg_i.leader_high;
    end else if (step_i == STEP_STOP) begin
      sched_o.delay = cfg_i.short_len;
    end else if (step_i == STEP_LAST) begin
      sched_o.delay  = cfg_i.repeat_gap;
      sched_o.stop   = (held_key_i == '0);
      sched_o.reload = (held_key_i != '0);
    end else if (step_i[0]) begin
      sched_o.delay = bit_one ? cfg_i.long_len : cfg_i.short_len;
    end else begin
      sched_o.delay = cfg_i.short_len;
    end
  end

endmodule

@@ hdl/nec_irfg_core.sv @@
// frame state registers and the per-item update of the line
// depends on nec_irfg_pkg and nec_irfg_sched
`timescale 1ns / 1ps

module nec_irfg_core
  import nec_irfg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [1:0]      opcode_i,
  input  logic [KeyW-1:0] key_code_i,
  input  nec_cfg_t        cfg_i,
  output nec_res_t        res_o
);

  logic [StepW-1:0]  step_q, step_d;
  logic [KeyW-1:0]   frame_q, frame_d;
  logic [KeyW-1:0]   held_q, held_d;
  logic [UnitsW-1:0] units_q, units_d;
  logic              pend_q, pend_d;
  logic              line_q, line_d;
  logic [StepW-1:0]  sched_step;
  nec_sched_t        sched;

  assign sched_step = (opcode_i == OP_PRESS) ? STEP_LEADER_LOW : step_q;

  nec_irfg_sched u_sched (
    .step_i       (sched_step),
    .frame_code_i (frame_q),
    .held_key_i   (held_q),
    .cfg_i        (cfg_i),
    .sched_o      (sched)
  );

  always_comb begin
    step_d  = step_q;
    frame_d = frame_q;
    held_d  = held_q;
    units_d = units_q;
    pend_d  = pend_q;
    line_d  = line_q;
    case (opcode_i)
      OP_TICK: begin
        if (frame_q != '0) begin
          if (units_q <= 12'd1) begin
            units_d = '0;
            line_d  = pend_q;
            if (sched.stop) begin
              frame_d = '0;
            end else begin
              if (sched.reload) begin
                frame_d = held_q;
              end
              pend_d  = sched.pend_level;
              units_d = sched.delay;
              step_d  = sched.next_step;
            end
          end else begin
            units_d = units_q - 12'd1;
          end
        end
      end
      OP_PRESS: begin
        if (frame_q != '0) begin
          held_d = key_code_i;
        end else if (key_code_i != '0) begin
          frame_d = key_code_i;
          held_d  = key_code_i;
          line_d  = 1'b0;
          pend_d  = sched.pend_level;
          units_d = sched.delay;
          step_d  = sched.next_step;
        end
      end
      OP_RELEASE: begin
        if (held_q == key_code_i) begin
          held_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.ir_level = line_d;
  assign res_o.active   = (frame_d != '0);
  assign res_o.edge_res = line_d ^ line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      frame_q <= '0;
      held_q  <= '0;
      units_q <= '0;
      pend_q  <= 1'b1;
      line_q  <= 1'b1;
    end else if (fire_i) begin
      step_q  <= step_d;
      frame_q <= frame_d;
      held_q  <= held_d;
      units_q <= units_d;
      pend_q  <= pend_d;
      line_q  <= line_d;
    end
  end

endmodule

@@ hdl/nec_irfg_obuf.sv @@
// two-entry result queue between the core and the result channel
// depends on nec_irfg_pkg
`timescale 1ns / 1ps

module nec_irfg_obuf
  import nec_irfg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  nec_res_t push_data_i,
  output logic     room_o,
  output logic     valid_o,
  input  logic     ready_i,
  output nec_res_t data_o
);

  logic [1:0] count_q, count_d;
  nec_res_t   slot0_q, slot0_d;
  nec_res_t   slot1_q, slot1_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q != 2'd2);
  assign data_o  = slot0_q;
  assign pop     = valid_o && ready_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    count_d = count_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_i) begin
      if ((count_q == 2'd0) || ((count_q == 2'd1) && pop)) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
    end
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule
